>>> src/hak_pkg.sv
// Shared types and codes for the hunt-and-kill maze carver.
package hak_pkg;

  typedef logic [4:0] coord_t;

  // Operation codes of an input item
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Direction codes
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_STARTED  = 3'd0;
  localparam logic [2:0] KIND_WALK     = 3'd1;
  localparam logic [2:0] KIND_HUNT     = 3'd2;
  localparam logic [2:0] KIND_FINISHED = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] start_col;
    logic [3:0] start_row;
    logic [1:0] dir_first;
    logic [1:0] dir_second;
    logic [1:0] dir_third;
    logic [1:0] dir_fourth;
    coord_t     read_row;
    coord_t     read_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    coord_t     pos_x;
    coord_t     pos_y;
    logic       wall;
  } out_item_t;

endpackage

>>> src/hunt_and_kill_maze_carver.sv
// Hunt-and-kill maze carver: row-wide grid memory with a read-modify-write sequencer.
//
//  channel | ports                          | direction | transfer when
//  --------+--------------------------------+-----------+---------------------------
//  input   | in_valid, in_stall, in_data    | in        | in_valid & !in_stall
//  result  | out_valid, out_stall, out_data | out       | out_valid & !out_stall
//  config  | cfg_we, cfg_data               | in        | cfg_we
//
// One item is worked at a time; in_stall is low only while the sequencer is idle.
// The length of an item is set by the grid memory (one row per entry, registered read
// data): a read waits for one row, a start writes every row to fill the grid with
// walls, a walk move reads the row of each tried direction that stays on the grid
// and then opens the target cell and the cell between, and a hunt loads three rows
// per odd row scanned, tests each odd column and carves the cell that it finds.
// Reset is synchronous and clears control state only; the grid holds garbage until
// the first start. A finished result waits in the output register without blocking
// the next input transfer.
module hunt_and_kill_maze_carver #(
  parameter int MAX_SIZE = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hak_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hak_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_data
);
  import hak_pkg::*;

  localparam int RW      = $clog2(MAX_SIZE);
  localparam int MAX_CAP = (MAX_SIZE < 31) ? MAX_SIZE : 31;

  typedef logic [MAX_SIZE-1:0] row_t;
  typedef logic [RW-1:0]       ridx_t;

  localparam row_t  ROW_ONE  = row_t'(1);
  localparam row_t  ROW_WALL = '1;
  localparam ridx_t ROW_LAST = ridx_t'(MAX_SIZE - 1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_WRD   = 4'd2;
  localparam logic [3:0] ST_WCHK  = 4'd3;
  localparam logic [3:0] ST_HLN   = 4'd4;
  localparam logic [3:0] ST_HLC   = 4'd5;
  localparam logic [3:0] ST_HLS   = 4'd6;
  localparam logic [3:0] ST_HCAP  = 4'd7;
  localparam logic [3:0] ST_HSCAN = 4'd8;
  localparam logic [3:0] ST_MRD   = 4'd9;
  localparam logic [3:0] ST_MWR   = 4'd10;
  localparam logic [3:0] ST_RWAIT = 4'd11;
  localparam logic [3:0] ST_EMIT  = 4'd12;

  // Effective side length: cap, force odd, floor at five.
  function automatic coord_t eff_size(input logic [4:0] s);
    coord_t v;
    v = s;
    if (v > coord_t'(MAX_CAP)) v = coord_t'(MAX_CAP);
    if (!v[0] && (v != 5'd0)) v = v - 5'd1;
    if (v < 5'd5) v = 5'd5;
    return v;
  endfunction

  logic [3:0]      state_r, state_nxt;
  logic [4:0]      grid_size_r;
  coord_t          n_r, n_nxt;
  coord_t          walk_x_r, walk_x_nxt;
  coord_t          walk_y_r, walk_y_nxt;
  logic            finished_r, finished_nxt;
  logic [3:0][1:0] dirs_r, dirs_nxt;
  logic [1:0]      dir_i_r, dir_i_nxt;
  coord_t          tx_r, tx_nxt;
  coord_t          ty_r, ty_nxt;
  coord_t          mx_r, mx_nxt;
  coord_t          my_r, my_nxt;
  coord_t          hr_r, hr_nxt;
  coord_t          hc_r, hc_nxt;
  row_t            row_n_r, row_n_nxt;
  row_t            row_c_r, row_c_nxt;
  row_t            row_s_r, row_s_nxt;
  ridx_t           clr_cnt_r, clr_cnt_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic            wall_r, wall_nxt;
  logic            rd_inb_r, rd_inb_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Grid memory: one row of wall bits per entry
  row_t  grid_mem [MAX_SIZE];
  row_t  rd_data_r;
  logic  mem_we;
  ridx_t mem_wa;
  ridx_t mem_ra;
  row_t  mem_wd;

  logic       in_xfer;
  logic       out_free;
  logic [1:0] dsel;
  logic       t_ok;
  coord_t     t_x, t_y, m_x, m_y;
  logic       h_wall, h_n, h_s, h_e, h_w;
  coord_t     half, ci, ri;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Candidate walk move for the current direction
  always_comb begin
    dsel = dirs_r[dir_i_r];
    t_ok = 1'b0;
    t_x  = walk_x_r;
    t_y  = walk_y_r;
    m_x  = walk_x_r;
    m_y  = walk_y_r;
    case (dsel)
      DIR_N: begin
        t_ok = (walk_y_r >= 5'd2);
        t_y  = walk_y_r - 5'd2;
        m_y  = walk_y_r - 5'd1;
      end
      DIR_S: begin
        t_ok = ({1'b0, walk_y_r} + 6'd2) < {1'b0, n_r};
        t_y  = walk_y_r + 5'd2;
        m_y  = walk_y_r + 5'd1;
      end
      DIR_E: begin
        t_ok = ({1'b0, walk_x_r} + 6'd2) < {1'b0, n_r};
        t_x  = walk_x_r + 5'd2;
        m_x  = walk_x_r + 5'd1;
      end
      default: begin
        t_ok = (walk_x_r >= 5'd2);
        t_x  = walk_x_r - 5'd2;
        m_x  = walk_x_r - 5'd1;
      end
    endcase
  end

  // Hunt test of one cell against the three buffered rows
  always_comb begin
    h_wall = row_c_r[ridx_t'(hc_r)];
    h_n    = (hr_r >= 5'd3) && !row_n_r[ridx_t'(hc_r)];
    h_s    = (({1'b0, hr_r} + 6'd2) < {1'b0, n_r}) && !row_s_r[ridx_t'(hc_r)];
    h_e    = (({1'b0, hc_r} + 6'd2) < {1'b0, n_r}) && !row_c_r[ridx_t'(hc_r + 5'd2)];
    h_w    = (hc_r >= 5'd3) && !row_c_r[ridx_t'(hc_r - 5'd2)];
  end

  // Start cell, saturated to the grid
  always_comb begin
    half = eff_size(grid_size_r) >> 1;
    ci   = ({1'b0, in_data.start_col} >= half) ? half - 5'd1 : {1'b0, in_data.start_col};
    ri   = ({1'b0, in_data.start_row} >= half) ? half - 5'd1 : {1'b0, in_data.start_row};
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    walk_x_nxt    = walk_x_r;
    walk_y_nxt    = walk_y_r;
    finished_nxt  = finished_r;
    dirs_nxt      = dirs_r;
    dir_i_nxt     = dir_i_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    hr_nxt        = hr_r;
    hc_nxt        = hc_r;
    row_n_nxt     = row_n_r;
    row_c_nxt     = row_c_r;
    row_s_nxt     = row_s_r;
    clr_cnt_nxt   = clr_cnt_r;
    kind_nxt      = kind_r;
    wall_nxt      = wall_r;
    rd_inb_nxt    = rd_inb_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = ridx_t'(ty_r);
    mem_wd        = rd_data_r;
    mem_ra        = ridx_t'(ty_r);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wall_nxt = 1'b0;
          case (in_data.op)
            OP_START: begin
              n_nxt        = eff_size(grid_size_r);
              walk_x_nxt   = {ci[3:0], 1'b1};
              walk_y_nxt   = {ri[3:0], 1'b1};
              finished_nxt = 1'b0;
              clr_cnt_nxt  = '0;
              state_nxt    = ST_CLR;
            end
            OP_STEP: begin
              dirs_nxt  = {in_data.dir_fourth, in_data.dir_third,
                           in_data.dir_second, in_data.dir_first};
              dir_i_nxt = 2'd0;
              if (finished_r) begin
                kind_nxt  = KIND_FINISHED;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_WRD;
              end
            end
            OP_READ: begin
              mem_ra     = ridx_t'(in_data.read_row);
              tx_nxt     = in_data.read_col;
              rd_inb_nxt = (in_data.read_row < n_r) && (in_data.read_col < n_r);
              state_nxt  = ST_RWAIT;
            end
            default: begin
              // unused opcode: drop the item
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CLR: begin
        // refill one row with walls; the start cell opens on its own row
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = ROW_WALL;
        if (clr_cnt_r == ridx_t'(walk_y_r)) mem_wd = ROW_WALL & ~(ROW_ONE << ridx_t'(walk_x_r));
        clr_cnt_nxt = clr_cnt_r + ridx_t'(1);
        if (clr_cnt_r == ROW_LAST) begin
          kind_nxt  = KIND_STARTED;
          state_nxt = ST_EMIT;
        end
      end

      ST_WRD: begin
        tx_nxt = t_x;
        ty_nxt = t_y;
        mx_nxt = m_x;
        my_nxt = m_y;
        mem_ra = ridx_t'(t_y);
        if (t_ok) begin
          state_nxt = ST_WCHK;
        end else if (dir_i_r == 2'd3) begin
          hr_nxt    = 5'd1;
          state_nxt = ST_HLN;
        end else begin
          dir_i_nxt = dir_i_r + 2'd1;
        end
      end

      ST_WCHK: begin
        if (rd_data_r[ridx_t'(tx_r)]) begin
          mem_we     = 1'b1;
          mem_wa     = ridx_t'(ty_r);
          mem_wd     = rd_data_r & ~(ROW_ONE << ridx_t'(tx_r));
          walk_x_nxt = tx_r;
          walk_y_nxt = ty_r;
          kind_nxt   = KIND_WALK;
          state_nxt  = ST_MRD;
        end else if (dir_i_r == 2'd3) begin
          hr_nxt    = 5'd1;
          state_nxt = ST_HLN;
        end else begin
          dir_i_nxt = dir_i_r + 2'd1;
          state_nxt = ST_WRD;
        end
      end

      // load rows r-2, r and r+2 of the hunt
      ST_HLN: begin
        mem_ra    = (hr_r >= 5'd3) ? ridx_t'(hr_r - 5'd2) : ridx_t'(hr_r);
        state_nxt = ST_HLC;
      end
      ST_HLC: begin
        row_n_nxt = rd_data_r;
        mem_ra    = ridx_t'(hr_r);
        state_nxt = ST_HLS;
      end
      ST_HLS: begin
        row_c_nxt = rd_data_r;
        mem_ra    = (({1'b0, hr_r} + 6'd2) < {1'b0, n_r}) ? ridx_t'(hr_r + 5'd2)
                                                          : ridx_t'(hr_r);
        state_nxt = ST_HCAP;
      end
      ST_HCAP: begin
        row_s_nxt = rd_data_r;
        hc_nxt    = 5'd1;
        state_nxt = ST_HSCAN;
      end

      ST_HSCAN: begin
        if (h_wall && (h_n || h_s || h_e || h_w)) begin
          mem_we     = 1'b1;
          mem_wa     = ridx_t'(hr_r);
          mem_wd     = row_c_r & ~(ROW_ONE << ridx_t'(hc_r));
          walk_x_nxt = hc_r;
          walk_y_nxt = hr_r;
          kind_nxt   = KIND_HUNT;
          mx_nxt     = hc_r;
          my_nxt     = hr_r;
          if (h_n)      my_nxt = hr_r - 5'd1;
          else if (h_s) my_nxt = hr_r + 5'd1;
          else if (h_e) mx_nxt = hc_r + 5'd1;
          else          mx_nxt = hc_r - 5'd1;
          state_nxt = ST_MRD;
        end else if (({1'b0, hc_r} + 6'd3) < {1'b0, n_r}) begin
          hc_nxt = hc_r + 5'd2;
        end else if (({1'b0, hr_r} + 6'd3) < {1'b0, n_r}) begin
          hr_nxt    = hr_r + 5'd2;
          state_nxt = ST_HLN;
        end else begin
          finished_nxt = 1'b1;
          kind_nxt     = KIND_FINISHED;
          state_nxt    = ST_EMIT;
        end
      end

      // open the cell between; its row may be the one just written
      ST_MRD: begin
        mem_ra    = ridx_t'(my_r);
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        mem_we    = 1'b1;
        mem_wa    = ridx_t'(my_r);
        mem_wd    = rd_data_r & ~(ROW_ONE << ridx_t'(mx_r));
        state_nxt = ST_EMIT;
      end

      ST_RWAIT: begin
        wall_nxt  = rd_inb_r ? rd_data_r[ridx_t'(tx_r)] : 1'b1;
        kind_nxt  = KIND_READ;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: kind_r, pos_x: walk_x_r, pos_y: walk_y_r, wall: wall_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    rd_data_r <= grid_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_size_r <= 5'd13;
      n_r         <= eff_size(5'd13);
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) grid_size_r <= cfg_data;
      n_r         <= n_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dirs_r     <= dirs_nxt;
    dir_i_r    <= dir_i_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    hr_r       <= hr_nxt;
    hc_r       <= hc_nxt;
    row_n_r    <= row_n_nxt;
    row_c_r    <= row_c_nxt;
    row_s_r    <= row_s_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
    kind_r     <= kind_nxt;
    wall_r     <= wall_nxt;
    rd_inb_r   <= rd_inb_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result only ever comes out of the emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (!$past(out_valid_r) || !$past(out_stall))) |-> $past(state_r) == ST_EMIT)
    else $error("result loaded outside emit state");

  // The grid is never written while idle or emitting.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE) && (state_r != ST_EMIT))
    else $error("grid write while idle");

  // The hunt only visits odd rows and columns.
  a_hunt_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HSCAN) |-> (hr_r[0] && hc_r[0]))
    else $error("hunt on even coordinate");

  // The walk always rests on an odd cell inside the grid once a maze exists.
  a_walk_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (!finished_r && state_r == ST_IDLE) |-> (walk_x_r[0] && walk_y_r[0] &&
                                             walk_x_r < n_r && walk_y_r < n_r))
    else $error("walk position off the odd lattice");

  // A step on a finished maze answers without touching the grid.
  a_finished_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.op == OP_STEP && finished_r) |=> state_r == ST_EMIT)
    else $error("step on finished maze did not answer at once");

endmodule
